>>> hdl/bsia_pkg.sv
// ----------------------------------------------------------------------------
// bsia_pkg: shared definitions for the bounded stack unit
// Sizes, operation and status codes, and the per-cell control bundle.
// ----------------------------------------------------------------------------
package bsia_pkg;

    localparam int DEPTH  = 8;
    localparam int DATA_W = 32;
    localparam int POS_W  = 4;
    localparam int CNT_W  = 4;
    localparam int IDX_W  = $clog2(DEPTH);

    typedef enum logic [1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_PEEK   = 2'd2,
        FUNC_CHANGE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_NOPOS     = 2'd3
    } status_t;

    // Control for one stack cell in one cycle.
    typedef struct packed {
        logic push;
        logic pop;
        logic load;
    } cell_ctrl_t;

endpackage

>>> hdl/bsia_req_if.sv
// ----------------------------------------------------------------------------
// bsia_req_if: request channel
// Valid/ready channel that carries one stack request per item.
// ----------------------------------------------------------------------------
interface bsia_req_if;

    logic                              valid;
    logic                              ready;
    logic [1:0]                        func;
    logic signed [bsia_pkg::DATA_W-1:0] value;
    logic [bsia_pkg::POS_W-1:0]        position;

    modport source (output valid, output func, output value, output position, input ready);
    modport sink   (input valid, input func, input value, input position, output ready);

endinterface

>>> hdl/bsia_rsp_if.sv
// ----------------------------------------------------------------------------
// bsia_rsp_if: response channel
// Valid/ready channel that carries one stack result per item.
// ----------------------------------------------------------------------------
interface bsia_rsp_if;

    logic                              valid;
    logic                              ready;
    logic signed [bsia_pkg::DATA_W-1:0] data;
    logic [1:0]                        status;
    logic [bsia_pkg::CNT_W-1:0]        fill_count;

    modport source (output valid, output data, output status, output fill_count, input ready);
    modport sink   (input valid, input data, input status, input fill_count, output ready);

endinterface

>>> hdl/bsia_cell.sv
// ----------------------------------------------------------------------------
// bsia_cell: one stack cell
// Holds one word; shifts down on push, up on pop, or loads on a change.
// ----------------------------------------------------------------------------
module bsia_cell (
    input  logic                               clk,
    input  bsia_pkg::cell_ctrl_t               ctrl,
    input  logic signed [bsia_pkg::DATA_W-1:0] up_data,
    input  logic signed [bsia_pkg::DATA_W-1:0] down_data,
    input  logic signed [bsia_pkg::DATA_W-1:0] value,
    output logic signed [bsia_pkg::DATA_W-1:0] entry
);

    logic signed [bsia_pkg::DATA_W-1:0] entry_reg;
    logic signed [bsia_pkg::DATA_W-1:0] entry_next;

    always_comb
    begin
        priority if (ctrl.push)
        begin
            entry_next = up_data;
        end
        else if (ctrl.pop)
        begin
            entry_next = down_data;
        end
        else if (ctrl.load)
        begin
            entry_next = value;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> hdl/bounded_stack_indexed_access_unit.sv
// ----------------------------------------------------------------------------
// bounded_stack_indexed_access_unit: LIFO stack with peek and change
// Fixed-depth stack built as a row of cells, one result per request.
// ----------------------------------------------------------------------------
// Usage:
// A request item on req carries func (push, pop, peek, change), value and
// position, where position 1 is the top of the stack. Every request gives
// exactly one result item on rsp with data, status and the fill count held
// after the request. Errors (push when full, pop when empty, a position of
// zero or above the fill count) leave the stack unchanged and return zero
// data with the matching status code.
// The stack is a row of DEPTH cells with the top in cell 0. A push shifts
// every cell one place down, a pop shifts every cell one place up, and a
// change loads the value into the one addressed cell, so each request is
// done in the cycle it is accepted. The result appears in the next cycle from
// an output register. Throughput is one item per cycle while rsp is taken;
// the cell row and fill count are updated as each request is accepted.
// When the receiver stalls, the result waits in the output register and req
// stays ready only if that register is being emptied in the same cycle.
// Reset empties the stack and drops any pending result; the cell words are
// not cleared, since no entry is ever read before it is written.
// ----------------------------------------------------------------------------
module bounded_stack_indexed_access_unit (
    input  logic       clk,
    input  logic       rst_n,
    bsia_req_if.sink   req,
    bsia_rsp_if.source rsp
);

    logic take;

    logic [bsia_pkg::CNT_W-1:0] count_reg;
    logic [bsia_pkg::CNT_W-1:0] count_next;

    logic                               rsp_valid_reg;
    logic                               rsp_valid_next;
    logic signed [bsia_pkg::DATA_W-1:0] data_reg;
    logic signed [bsia_pkg::DATA_W-1:0] data_next;
    logic [1:0]                         status_reg;
    logic [1:0]                         status_next;
    logic [bsia_pkg::CNT_W-1:0]         fill_reg;

    logic                       push_ok;
    logic                       pop_ok;
    logic                       pos_ok;
    logic [bsia_pkg::POS_W-1:0] pos_m1;
    logic [bsia_pkg::IDX_W-1:0] idx;

    logic signed [bsia_pkg::DATA_W-1:0] entry [bsia_pkg::DEPTH];
    bsia_pkg::cell_ctrl_t               ctrl  [bsia_pkg::DEPTH];

    // A new request is taken whenever the output register is free or is
    // being drained in this cycle.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign take      = req.valid && req.ready;

    assign push_ok = (count_reg != bsia_pkg::CNT_W'(bsia_pkg::DEPTH));
    assign pop_ok  = (count_reg != '0);
    assign pos_ok  = (req.position != '0) && (req.position <= count_reg);
    assign pos_m1  = req.position - bsia_pkg::POS_W'(1);
    assign idx     = pos_m1[bsia_pkg::IDX_W-1:0];

    // Decode the request into the operation result and the new fill count.
    always_comb
    begin
        count_next  = count_reg;
        data_next   = '0;
        status_next = bsia_pkg::ST_OK;
        unique case (req.func)
            bsia_pkg::FUNC_PUSH:
            begin
                if (push_ok)
                begin
                    count_next = count_reg + bsia_pkg::CNT_W'(1);
                end
                else
                begin
                    status_next = bsia_pkg::ST_OVERFLOW;
                end
            end
            bsia_pkg::FUNC_POP:
            begin
                if (pop_ok)
                begin
                    count_next = count_reg - bsia_pkg::CNT_W'(1);
                    data_next  = entry[0];
                end
                else
                begin
                    status_next = bsia_pkg::ST_UNDERFLOW;
                end
            end
            bsia_pkg::FUNC_PEEK:
            begin
                if (pos_ok)
                begin
                    data_next = entry[idx];
                end
                else
                begin
                    status_next = bsia_pkg::ST_NOPOS;
                end
            end
            default:
            begin
                if (!pos_ok)
                begin
                    status_next = bsia_pkg::ST_NOPOS;
                end
            end
        endcase
    end

    // The row of cells. Cell 0 is the top; its upper neighbor is the pushed
    // value, and the bottom cell pulls in zero when the stack shifts up.
    for (genvar i = 0; i < bsia_pkg::DEPTH; i++)
    begin : g_cell
        logic signed [bsia_pkg::DATA_W-1:0] up_data;
        logic signed [bsia_pkg::DATA_W-1:0] down_data;

        if (i == 0)
        begin : g_top
            assign up_data = req.value;
        end
        else
        begin : g_mid_up
            assign up_data = entry[i-1];
        end

        if (i == bsia_pkg::DEPTH - 1)
        begin : g_bottom
            assign down_data = '0;
        end
        else
        begin : g_mid_down
            assign down_data = entry[i+1];
        end

        assign ctrl[i].push = take && (req.func == bsia_pkg::FUNC_PUSH) && push_ok;
        assign ctrl[i].pop  = take && (req.func == bsia_pkg::FUNC_POP) && pop_ok;
        assign ctrl[i].load = take && (req.func == bsia_pkg::FUNC_CHANGE) && pos_ok
                              && (idx == bsia_pkg::IDX_W'(i));

        bsia_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl[i]),
            .up_data   (up_data),
            .down_data (down_data),
            .value     (req.value),
            .entry     (entry[i])
        );
    end

    always_comb
    begin
        priority if (take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (take)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Result payload, loaded with each accepted request.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg   <= data_next;
            status_reg <= status_next;
            fill_reg   <= count_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.data       = data_reg;
    assign rsp.status     = status_reg;
    assign rsp.fill_count = fill_reg;

endmodule

>>> tb/tb_bounded_stack_indexed_access_unit.sv
// ----------------------------------------------------------------------------
// tb_bounded_stack_indexed_access_unit: self-checking bench for the stack unit
// Drives push, pop, peek and change requests through the valid/ready request
// channel, predicts every result from a shadow copy of the stack, and checks
// data, status and fill count of each result item in order. The run moves
// through phases with different sender and receiver idling, and the receiver
// holds off for long stretches so that the unit backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb_bounded_stack_indexed_access_unit;

    // One request item as the sender sees it.
    typedef struct {
        bsia_pkg::func_t                    func;
        logic signed [bsia_pkg::DATA_W-1:0] value;
        logic [bsia_pkg::POS_W-1:0]         position;
    } stack_req_t;

    // One result item as the receiver should see it.
    typedef struct {
        logic signed [bsia_pkg::DATA_W-1:0] data;
        bsia_pkg::status_t                  status;
        logic [bsia_pkg::CNT_W-1:0]         fill_count;
    } stack_rsp_t;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int RESULT_LATENCY = 1;
    localparam int PHASE_ITEMS    = 310;
    localparam int NUM_PHASES     = 4;
    localparam int HOLD_LEN       = 64;
    localparam int HOLD_FIRST     = 100;
    localparam int HOLD_GAP       = 900;
    localparam int REPORT_MAX     = 10;

    // Idling per phase, in percent: none, sender slow, receiver slow, both a little.
    localparam int SEND_IDLE [NUM_PHASES] = '{0, 81, 0, 6};
    localparam int RECV_STALL[NUM_PHASES] = '{0, 0, 81, 6};

    logic clk;
    logic rst_n;

    bsia_req_if req_ch ();
    bsia_rsp_if rsp_ch ();

    bounded_stack_indexed_access_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Requests waiting to be offered, and results predicted but not yet seen.
    stack_req_t pending_reqs[$];
    stack_rsp_t expected_rsps[$];
    stack_req_t next_req;

    // Shadow of the stack contents and fill level, updated on each accepted item.
    logic signed [bsia_pkg::DATA_W-1:0] model_words[bsia_pkg::DEPTH];
    int                                 model_fill = 0;

    // Fill level as the request generator expects it when it queues an item.
    // It only steers the choice of operations; checking relies on the shadow.
    int gen_fill = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int accepted_cnt   = 0;
    int mismatch_cnt   = 0;
    int cycle_cnt      = 0;
    int hold_left      = 0;
    int next_hold_at   = HOLD_FIRST;
    int phase;

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // The watchdog catches a hung handshake or a result that never arrives.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_cnt, expected_rsps.size());
            $display("tb_bounded_stack_indexed_access_unit NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    // Applies one request to the shadow stack and returns the result the unit
    // must produce for it. Errors leave the shadow untouched and give zero data.
    // Position 1 is the top, which sits at index model_fill - 1.
    function automatic stack_rsp_t apply_stack_op(bsia_pkg::func_t op,
                                                  logic signed [bsia_pkg::DATA_W-1:0] word,
                                                  logic [bsia_pkg::POS_W-1:0] pos);
        stack_rsp_t res;
        res.data   = '0;
        res.status = bsia_pkg::ST_OK;
        case (op)
            bsia_pkg::FUNC_PUSH:
            begin
                if (model_fill >= bsia_pkg::DEPTH)
                    res.status = bsia_pkg::ST_OVERFLOW;
                else
                begin
                    model_words[model_fill] = word;
                    model_fill++;
                end
            end
            bsia_pkg::FUNC_POP:
            begin
                if (model_fill == 0)
                    res.status = bsia_pkg::ST_UNDERFLOW;
                else
                begin
                    model_fill--;
                    res.data = model_words[model_fill];
                end
            end
            bsia_pkg::FUNC_PEEK:
            begin
                if (pos == 0 || int'(pos) > model_fill)
                    res.status = bsia_pkg::ST_NOPOS;
                else
                    res.data = model_words[model_fill - int'(pos)];
            end
            default:
            begin
                if (pos == 0 || int'(pos) > model_fill)
                    res.status = bsia_pkg::ST_NOPOS;
                else
                    model_words[model_fill - int'(pos)] = word;
            end
        endcase
        res.fill_count = bsia_pkg::CNT_W'(model_fill);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request generation
    // ------------------------------------------------------------------------
    task automatic queue_request(bsia_pkg::func_t op,
                                 logic signed [bsia_pkg::DATA_W-1:0] word,
                                 logic [bsia_pkg::POS_W-1:0] pos);
        stack_req_t item;
        item.func     = op;
        item.value    = word;
        item.position = pos;
        pending_reqs.push_back(item);
        if (op == bsia_pkg::FUNC_PUSH && gen_fill < bsia_pkg::DEPTH)
            gen_fill++;
        else if (op == bsia_pkg::FUNC_POP && gen_fill > 0)
            gen_fill--;
    endtask

    // Mostly random words, with the corner words showing up now and then.
    function automatic logic signed [bsia_pkg::DATA_W-1:0] pick_word();
        case ($urandom_range(19))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Most positions land on a held entry; the rest cover the whole 4-bit field,
    // zero and positions past the fill level included.
    function automatic logic [bsia_pkg::POS_W-1:0] pick_position();
        if (gen_fill > 0 && $urandom_range(99) < 80)
            return bsia_pkg::POS_W'($urandom_range(gen_fill, 1));
        return bsia_pkg::POS_W'($urandom_range(15));
    endfunction

    // Random traffic. Short runs of pushes or pops drive the stack to full and
    // to empty so that overflow and underflow keep happening; otherwise the mix
    // leans toward pushes when nearly empty and toward pops when full.
    task automatic queue_random_requests(int n);
        int              made;
        int              roll;
        int              k;
        bsia_pkg::func_t op;
        made = 0;
        while (made < n)
        begin
            roll = $urandom_range(99);
            if (roll < 4)
            begin
                for (k = 0; k <= bsia_pkg::DEPTH; k++)
                    queue_request(bsia_pkg::FUNC_PUSH, pick_word(), pick_position());
                made += bsia_pkg::DEPTH + 1;
            end
            else if (roll < 8)
            begin
                for (k = 0; k <= bsia_pkg::DEPTH; k++)
                    queue_request(bsia_pkg::FUNC_POP, pick_word(), pick_position());
                made += bsia_pkg::DEPTH + 1;
            end
            else
            begin
                op = bsia_pkg::func_t'($urandom_range(3));
                if (gen_fill < 2 && $urandom_range(2) != 0)
                    op = bsia_pkg::FUNC_PUSH;
                else if (gen_fill == bsia_pkg::DEPTH && $urandom_range(2) != 0)
                    op = bsia_pkg::FUNC_POP;
                queue_request(op, pick_word(), pick_position());
                made++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    // On every edge where the current item is taken, its expected result is
    // predicted right away, so the expectation always exists before the unit
    // can return the matching result from its register. A new item is offered
    // whenever the channel is free, unless the sender chooses to stay idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid    <= 1'b0;
            req_ch.func     <= bsia_pkg::FUNC_PUSH;
            req_ch.value    <= '0;
            req_ch.position <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_rsps.push_back(apply_stack_op(bsia_pkg::func_t'(req_ch.func),
                                                       req_ch.value,
                                                       req_ch.position));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_req = pending_reqs.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.func     <= next_req.func;
                    req_ch.value    <= next_req.value;
                    req_ch.position <= next_req.position;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver hold-off
    // ------------------------------------------------------------------------
    // Once the accepted count passes a mark, the receiver refuses results for
    // a long stretch while the sender keeps offering items. The unit has to
    // fill its output register and then drop ready on the request side.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left    <= 0;
            next_hold_at <= HOLD_FIRST;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (accepted_cnt >= next_hold_at)
        begin
            hold_left    <= HOLD_LEN;
            next_hold_at <= next_hold_at + HOLD_GAP;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor and checker
    // ------------------------------------------------------------------------
    // Results come back in request order, so each one is held against the
    // oldest expectation. The first few mismatches are printed in full.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    if (mismatch_cnt < REPORT_MAX)
                        $display("unexpected result: data=%0d status=%0d fill=%0d",
                                 rsp_ch.data, rsp_ch.status, rsp_ch.fill_count);
                    mismatch_cnt++;
                end
                else if (rsp_ch.data !== expected_rsps[0].data ||
                         rsp_ch.status !== expected_rsps[0].status ||
                         rsp_ch.fill_count !== expected_rsps[0].fill_count)
                begin
                    if (mismatch_cnt < REPORT_MAX)
                    begin
                        $display("mismatch at cycle %0d: expected data=%0d status=%s fill=%0d",
                                 cycle_cnt, expected_rsps[0].data,
                                 expected_rsps[0].status.name(),
                                 expected_rsps[0].fill_count);
                        $display("    got data=%0d status=%0d fill=%0d",
                                 rsp_ch.data, rsp_ch.status, rsp_ch.fill_count);
                    end
                    mismatch_cnt++;
                    void'(expected_rsps.pop_front());
                end
                else
                begin
                    void'(expected_rsps.pop_front());
                end
            end
            rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // Every input of the unit is known from time zero on.
        req_ch.valid    = 1'b0;
        req_ch.func     = bsia_pkg::FUNC_PUSH;
        req_ch.value    = '0;
        req_ch.position = '0;
        rsp_ch.ready    = 1'b0;
        rst_n           = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            send_idle_pct  = SEND_IDLE[phase];
            recv_stall_pct = RECV_STALL[phase];

            if (phase == 0)
            begin
                // Errors on the empty stack: pop, a peek at the top, and a
                // change at position zero.
                queue_request(bsia_pkg::FUNC_POP, 32'sd0, 4'd0);
                queue_request(bsia_pkg::FUNC_PEEK, 32'sd0, 4'd1);
                queue_request(bsia_pkg::FUNC_CHANGE, 32'sh1234_5678, 4'd0);
                // Fill to full depth with corner words, then one push too many.
                queue_request(bsia_pkg::FUNC_PUSH, 32'sh8000_0000, 4'd0);
                queue_request(bsia_pkg::FUNC_PUSH, 32'sh7FFF_FFFF, 4'd15);
                queue_request(bsia_pkg::FUNC_PUSH, -32'sd1, 4'd0);
                queue_request(bsia_pkg::FUNC_PUSH, 32'sd0, 4'd15);
                queue_request(bsia_pkg::FUNC_PUSH, 32'sh5555_5555, 4'd0);
                queue_request(bsia_pkg::FUNC_PUSH, 32'shAAAA_AAAA, 4'd0);
                queue_request(bsia_pkg::FUNC_PUSH, 32'sd1, 4'd0);
                queue_request(bsia_pkg::FUNC_PUSH, 32'sh1234_5678, 4'd0);
                queue_request(bsia_pkg::FUNC_PUSH, 32'shDEAD_BEEF, 4'd0);
                // Peeks at the top, the bottom, just past the bottom, the field
                // maximum and zero.
                queue_request(bsia_pkg::FUNC_PEEK, 32'sd0, 4'd1);
                queue_request(bsia_pkg::FUNC_PEEK, 32'sd0, 4'd8);
                queue_request(bsia_pkg::FUNC_PEEK, 32'sd0, 4'd9);
                queue_request(bsia_pkg::FUNC_PEEK, 32'sd0, 4'd15);
                queue_request(bsia_pkg::FUNC_PEEK, 32'sd0, 4'd0);
                // Changes at the bottom, the top, and past the bottom, then
                // read the changed entries back.
                queue_request(bsia_pkg::FUNC_CHANGE, 32'sh7FFF_FFFF, 4'd8);
                queue_request(bsia_pkg::FUNC_CHANGE, 32'sh8000_0000, 4'd1);
                queue_request(bsia_pkg::FUNC_CHANGE, 32'sd5, 4'd9);
                queue_request(bsia_pkg::FUNC_PEEK, 32'sd0, 4'd8);
                queue_request(bsia_pkg::FUNC_POP, 32'sd0, 4'd0);
                queue_request(bsia_pkg::FUNC_POP, 32'sd0, 4'd0);
                queue_request(bsia_pkg::FUNC_PEEK, 32'sd0, 4'd6);
            end
            queue_random_requests(PHASE_ITEMS);

            // Let the sender run dry before the idling changes.
            while (pending_reqs.size() != 0 || req_ch.valid)
                @(negedge clk);
        end

        // Wait for the last results, then a few more cycles so that a stray
        // extra result would still be caught by the monitor.
        while (expected_rsps.size() != 0)
            @(negedge clk);
        repeat (RESULT_LATENCY + 8) @(posedge clk);

        if (mismatch_cnt == 0 && expected_rsps.size() == 0)
        begin
            $display("tb_bounded_stack_indexed_access_unit OK");
        end
        else
        begin
            $display("tb_bounded_stack_indexed_access_unit NOT OK");
        end
        $finish;
    end

endmodule
